FILE: sv/jgr_pkg.sv
// shared types and constants for the jacobi grid relaxation block
package jgr_pkg;

  localparam int unsigned CmdW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_GRID_SIZE  = 2'd0,
    REG_EPSILON    = 2'd1,
    REG_MAX_SWEEPS = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_e;

  localparam int unsigned SweepW = 16;
  localparam int unsigned SizeW  = 7;

  // controller to datapath
  typedef struct packed {
    logic       wr_cell;   // write input cell to both copies
    logic       rd_cell;   // read newest copy at input address
    logic       sweep_clr; // clear change max, start sweep
    logic       sweep_rd;  // issue stencil reads for current cell
    logic       sweep_wr;  // write result of current cell
    logic       flip;      // swap copies
  } dp_cmd_t;

endpackage

FILE: sv/jacobi_grid_relaxation.sv
// top level: jacobi relaxation with 5-point stencil on a square grid
//  channel | dir | contents
//  s_axis  | in  | tdata: cmd[1:0] row[7:2] col[13:8] value[36:14], pad to 40
//  m_axis  | out | tdata: cell_value[22:0] sweep_count[38:23] final_change[61:39]
//          |     |        hit_limit[62], pad to 64
//  cfg     | in  | index 0 grid_size, 1 epsilon, 2 max_sweeps
// write and unused command: result offered the cycle after the transfer
// read: the stored value is captured in the read state, then the result is offered
// run: each sweep scans every cell, then goes through drain and settle (stencil pipeline empties) and check
// stores have no reset and no clearing pass; newest copy flag resets to copy a
// result stays until taken; no new transfer before that
module jacobi_grid_relaxation #(
  parameter int unsigned MAX_DIM   = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // cmd, row, col, value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // cell_value, sweep_count, final_change, hit_limit
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [22:0] cfg_data_i
);
  import jgr_pkg::*;

  localparam int unsigned IdxW  = $clog2(MAX_DIM);
  localparam int unsigned CellW = 7 + FRAC_BITS;

  logic [SizeW-1:0]  grid_size_q;
  logic [CellW-1:0]  eps_q;
  logic [SweepW-1:0] max_sweeps_q;
  dp_cmd_t           dp_cmd;
  logic [IdxW-1:0]   row, col;
  logic              interior, above_eps;
  logic [CellW-1:0]  rd_data, change, cell_value, final_change;
  logic [SweepW-1:0] sweep_count;
  logic              hit_limit;
  logic              in_range;

  cmd_e              in_cmd;
  logic [5:0]        in_row, in_col;
  logic [CellW-1:0]  in_value;

  assign in_cmd   = cmd_e'(s_axis_tdata[1:0]);
  assign in_row   = s_axis_tdata[7:2];
  assign in_col   = s_axis_tdata[13:8];
  assign in_value = CellW'(s_axis_tdata[36:14]);
  assign in_range = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q  <= SizeW'(64);
      eps_q        <= CellW'(65536);
      max_sweeps_q <= SweepW'(65535);
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_GRID_SIZE:  grid_size_q  <= cfg_data_i[SizeW-1:0];
        REG_EPSILON:    eps_q        <= CellW'(cfg_data_i);
        REG_MAX_SWEEPS: max_sweeps_q <= cfg_data_i[SweepW-1:0];
        default: ;
      endcase
    end
  end

  jgr_ctrl #(.MaxDim(MAX_DIM), .IdxW(IdxW), .CellW(CellW)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(in_cmd), .row_i(IdxW'(in_row)), .col_i(IdxW'(in_col)), .inside_i(in_range),
    .grid_size_i(grid_size_q), .max_sweeps_i(max_sweeps_q),
    .rd_data_i(rd_data), .change_i(change), .above_eps_i(above_eps),
    .dp_cmd_o(dp_cmd), .row_o(row), .col_o(col), .interior_o(interior),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cell_value_o(cell_value), .sweep_count_o(sweep_count),
    .final_change_o(final_change), .hit_limit_o(hit_limit)
  );

  jgr_datapath #(.MaxDim(MAX_DIM), .FracBits(FRAC_BITS), .IdxW(IdxW), .CellW(CellW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .row_i(row), .col_i(col), .value_i(in_value),
    .interior_i(interior), .epsilon_i(eps_q), .rd_data_o(rd_data),
    .change_o(change), .above_eps_o(above_eps)
  );

  assign m_axis_tdata = {1'b0, hit_limit, 23'(final_change), sweep_count, 23'(cell_value)};

endmodule

FILE: sv/jgr_datapath.sv
// grid stores, stencil arithmetic and change tracking
module jgr_datapath #(
  parameter int unsigned MaxDim   = 64,
  parameter int unsigned FracBits = 16,
  parameter int unsigned IdxW     = 6,
  parameter int unsigned CellW    = 7 + FracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jgr_pkg::dp_cmd_t    cmd_i,
  input  logic [IdxW-1:0]     row_i,
  input  logic [IdxW-1:0]     col_i,
  input  logic [CellW-1:0]    value_i,
  input  logic                interior_i,
  input  logic [CellW-1:0]    epsilon_i,
  output logic [CellW-1:0]    rd_data_o,
  output logic [CellW-1:0]    change_o,
  output logic                above_eps_o
);
  import jgr_pkg::*;

  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned Depth = 1 << AddrW;

  // three banks per copy hold the same data so the five reads take at most two ports per bank
  logic [CellW-1:0] mem_a0 [Depth];
  logic [CellW-1:0] mem_a1 [Depth];
  logic [CellW-1:0] mem_a2 [Depth];
  logic [CellW-1:0] mem_b0 [Depth];
  logic [CellW-1:0] mem_b1 [Depth];
  logic [CellW-1:0] mem_b2 [Depth];

  logic newest_q;
  logic [AddrW-1:0] at, at_n, at_s, at_e, at_w;
  logic [AddrW-1:0] wa1_q, wa2_q, wa;
  logic [CellW-1:0] a_c_q, a_n_q, a_s_q, a_e_q, a_w_q;
  logic [CellW-1:0] b_c_q, b_n_q, b_s_q, b_e_q, b_w_q;
  logic [CellW-1:0] wdata;
  logic             we_a, we_b;
  logic [CellW-1:0] c_v, n_v, s_v, e_v, w_v;
  logic [CellW+1:0] sum;
  logic [CellW-1:0] nv, diff;
  logic [CellW-1:0] res_q, diff_q;
  logic             int_q;
  logic [CellW-1:0] change_q;

  assign at   = {row_i, col_i};
  assign at_n = {row_i - IdxW'(1), col_i};
  assign at_s = {row_i + IdxW'(1), col_i};
  assign at_e = {row_i, col_i + IdxW'(1)};
  assign at_w = {row_i, col_i - IdxW'(1)};

  assign c_v = newest_q ? b_c_q : a_c_q;
  assign n_v = newest_q ? b_n_q : a_n_q;
  assign s_v = newest_q ? b_s_q : a_s_q;
  assign e_v = newest_q ? b_e_q : a_e_q;
  assign w_v = newest_q ? b_w_q : a_w_q;

  assign sum  = (CellW+2)'(n_v) + (CellW+2)'(s_v) + (CellW+2)'(e_v) + (CellW+2)'(w_v);
  assign nv   = sum[CellW+1:2];
  assign diff = (nv >= c_v) ? nv - c_v : c_v - nv;

  // stage 2: result registered, written at the sweep_wr step with its address
  always_ff @(posedge clk_i) begin
    if (int_q) begin
      res_q <= nv;
    end else begin
      res_q <= c_v;
    end
    diff_q <= int_q ? diff : '0;
    if (cmd_i.sweep_rd) begin
      wa1_q <= at;
    end
    wa2_q <= wa1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q <= 1'b0;
    end else if (cmd_i.sweep_rd) begin
      int_q <= interior_i;
    end
  end

  // cell writes use the input address, sweep write-back uses the read address delayed through wa1_q and wa2_q
  assign wa    = cmd_i.wr_cell ? at : wa2_q;
  assign wdata = cmd_i.wr_cell ? value_i : res_q;
  assign we_a  = cmd_i.wr_cell || (cmd_i.sweep_wr && newest_q);
  assign we_b  = cmd_i.wr_cell || (cmd_i.sweep_wr && !newest_q);

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a0[wa] <= wdata;
      mem_a1[wa] <= wdata;
      mem_a2[wa] <= wdata;
    end
    a_c_q <= mem_a0[at];
    a_n_q <= mem_a0[at_n];
    a_s_q <= mem_a1[at_s];
    a_e_q <= mem_a1[at_e];
    a_w_q <= mem_a2[at_w];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b0[wa] <= wdata;
      mem_b1[wa] <= wdata;
      mem_b2[wa] <= wdata;
    end
    b_c_q <= mem_b0[at];
    b_n_q <= mem_b0[at_n];
    b_s_q <= mem_b1[at_s];
    b_e_q <= mem_b1[at_e];
    b_w_q <= mem_b2[at_w];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= 1'b0;
      change_q <= '0;
    end else begin
      if (cmd_i.flip) begin
        newest_q <= ~newest_q;
      end
      if (cmd_i.sweep_clr) begin
        change_q <= '0;
      end else if (cmd_i.sweep_wr && diff_q > change_q) begin
        change_q <= diff_q;
      end
    end
  end

  assign rd_data_o   = c_v;
  assign change_o    = change_q;
  assign above_eps_o = change_q > epsilon_i;

endmodule

FILE: sv/jgr_ctrl.sv
// command sequencer: cell access and sweep scan over the grid
module jgr_ctrl #(
  parameter int unsigned MaxDim = 64,
  parameter int unsigned IdxW   = 6,
  parameter int unsigned CellW  = 23
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  jgr_pkg::cmd_e                cmd_i,
  input  logic [IdxW-1:0]              row_i,
  input  logic [IdxW-1:0]              col_i,
  input  logic                         inside_i,
  input  logic [jgr_pkg::SizeW-1:0]    grid_size_i,
  input  logic [jgr_pkg::SweepW-1:0]   max_sweeps_i,
  input  logic [CellW-1:0]             rd_data_i,
  input  logic [CellW-1:0]             change_i,
  input  logic                         above_eps_i,
  output jgr_pkg::dp_cmd_t             dp_cmd_o,
  output logic [IdxW-1:0]              row_o,
  output logic [IdxW-1:0]              col_o,
  output logic                         interior_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [CellW-1:0]             cell_value_o,
  output logic [jgr_pkg::SweepW-1:0]   sweep_count_o,
  output logic [CellW-1:0]             final_change_o,
  output logic                         hit_limit_o
);
  import jgr_pkg::*;

  localparam int unsigned DimW = $clog2(MaxDim + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_READ   = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_DRAIN  = 7'b0001000,
    ST_SETTLE = 7'b0010000,
    ST_CHECK  = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [IdxW-1:0] r_q, r_d, c_q, c_d;
  logic            wr_v_q, wr_v2_q;
  logic [DimW-1:0] n_q;
  logic [SweepW-1:0] lim_q, cnt_q;
  logic [CellW-1:0]  cv_q, fc_q;
  logic              hl_q;
  logic              accept, last_cell, rd_inside_q;
  logic [DimW-1:0]   n_clip;
  logic [IdxW-1:0]   n_last;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_o;
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    if (grid_size_i < SizeW'(3)) begin
      n_clip = DimW'(3);
    end else if (32'(grid_size_i) > MaxDim) begin
      n_clip = DimW'(MaxDim);
    end else begin
      n_clip = DimW'(grid_size_i);
    end
  end
  assign n_last    = IdxW'(n_q - DimW'(1));
  assign last_cell = (r_q == n_last) && (c_q == n_last);

  always_comb begin
    r_d = r_q;
    c_d = c_q;
    if (state_q == ST_SCAN) begin
      if (c_q == n_last) begin
        c_d = '0;
        r_d = r_q + IdxW'(1);
      end else begin
        c_d = c_q + IdxW'(1);
      end
    end else if (accept || state_q == ST_DRAIN) begin
      r_d = '0;
      c_d = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_READ: state_d = ST_READ;
            CMD_RUN:  state_d = ST_SCAN;
            default:  state_d = ST_OUT;
          endcase
        end
      end
      ST_READ:   state_d = ST_OUT;
      ST_SCAN:   if (last_cell) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_SETTLE;
      ST_SETTLE: state_d = ST_CHECK;
      ST_CHECK: begin
        if (above_eps_i && cnt_q < lim_q) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q <= '0;
      c_q <= '0;
      wr_v_q <= 1'b0;
      wr_v2_q <= 1'b0;
      cnt_q <= '0;
      hl_q <= 1'b0;
      rd_inside_q <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q <= r_d;
      c_q <= c_d;
      wr_v_q <= (state_q == ST_SCAN);
      wr_v2_q <= wr_v_q;
      if (accept) begin
        cnt_q <= '0;
        hl_q <= 1'b0;
        rd_inside_q <= inside_i;
      end
      if (state_q == ST_DRAIN) begin
        cnt_q <= cnt_q + SweepW'(1);
      end
      if (state_q == ST_CHECK && state_d == ST_OUT) begin
        hl_q <= above_eps_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q   <= n_clip;
      lim_q <= (max_sweeps_i == '0) ? SweepW'(1) : max_sweeps_i;
      cv_q  <= '0;
      fc_q  <= '0;
    end
    if (state_q == ST_READ) begin
      cv_q <= rd_inside_q ? rd_data_i : '0;
    end
    if (state_q == ST_CHECK) begin
      fc_q <= change_i;
    end
  end

  // write-back of the last cell lands in settle, so the swap waits until then
  always_comb begin
    dp_cmd_o = '0;
    dp_cmd_o.wr_cell   = accept && (cmd_i == CMD_WRITE) && inside_i;
    dp_cmd_o.rd_cell   = accept && (cmd_i == CMD_READ);
    dp_cmd_o.sweep_clr = (accept && cmd_i == CMD_RUN) || (state_q == ST_CHECK);
    dp_cmd_o.sweep_rd  = (state_q == ST_SCAN);
    dp_cmd_o.sweep_wr  = wr_v2_q;
    dp_cmd_o.flip      = (state_q == ST_SETTLE);
  end

  // address to stores: input address on transfer, scan address otherwise
  always_comb begin
    if (state_q == ST_IDLE) begin
      row_o = row_i;
      col_o = col_i;
    end else begin
      row_o = r_q;
      col_o = c_q;
    end
  end
  assign interior_o = (r_q != '0) && (c_q != '0) && (r_q != n_last) && (c_q != n_last);

  assign cell_value_o   = cv_q;
  assign sweep_count_o  = cnt_q;
  assign final_change_o = fc_q;
  assign hit_limit_o    = hl_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_cnt_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> cnt_q <= lim_q && cnt_q != '0) else $error("sweep count");

endmodule

FILE: test/tb.sv
// self-checking testbench for the jacobi grid relaxation block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jgr_pkg::*;

  localparam int Dim = 64;
  localparam int Cells = Dim * Dim;
  localparam longint CycleLimit = 30_000_000;
  localparam int RandomItems = 500;
  localparam int Phases = 10;

  // result fields from msb down: hit_limit, final_change, sweep_count, cell_value
  typedef struct packed {
    logic        hit;
    logic [22:0] change;
    logic [15:0] sweeps;
    logic [22:0] value;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // cmd, row, col, value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // cell_value, sweep_count, final_change, hit_limit
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [22:0] cfg_data_i = '0;

  jacobi_grid_relaxation dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow grid and settings
  logic [22:0] grid_copy [2][Cells];
  bit          newest;
  bit          written [Cells];
  int unsigned size_reg = 64;
  int unsigned eps_reg = 65536;
  int unsigned sweeps_reg = 65535;

  outcome_t    expected_q[$];
  int          errors = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          runs_sent = 0;
  int          limit_hits = 0;
  longint      cycles = 0;
  bit          quiet = 1'b1;
  int          stall_left = 0;

  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  // one jacobi pass from the newest copy into the other, returns the largest change
  function automatic logic [22:0] relax_pass(int unsigned n);
    logic [24:0] sum;
    logic [22:0] nv, old, d, most;
    int at;
    int src, dst;
    src = newest;
    dst = !newest;
    most = '0;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        at = r * Dim + c;
        if (r == 0 || c == 0 || r == n - 1 || c == n - 1) begin
          grid_copy[dst][at] = grid_copy[src][at];
        end else begin
          sum = 25'(grid_copy[src][at - Dim]) + 25'(grid_copy[src][at + 1]) +
                25'(grid_copy[src][at + Dim]) + 25'(grid_copy[src][at - 1]);
          nv = sum[24:2];
          old = grid_copy[src][at];
          d = (nv >= old) ? nv - old : old - nv;
          grid_copy[dst][at] = nv;
          if (d > most) most = d;
        end
      end
    end
    return most;
  endfunction

  function automatic outcome_t predict_grid(cmd_e cmd, int row, int col, logic [22:0] val);
    outcome_t o;
    int at;
    int unsigned n, lim, cnt;
    logic [22:0] chg;
    o = '0;
    at = row * Dim + col;
    case (cmd)
      CMD_WRITE: begin
        grid_copy[0][at] = val;
        grid_copy[1][at] = val;
        written[at] = 1'b1;
      end
      CMD_RUN: begin
        n = size_reg < 3 ? 3 : (size_reg > Dim ? Dim : size_reg);
        lim = sweeps_reg == 0 ? 1 : sweeps_reg;
        cnt = 0;
        do begin
          chg = relax_pass(n);
          newest = !newest;
          cnt++;
        end while (chg > eps_reg && cnt < lim);
        o.sweeps = cnt[15:0];
        o.change = chg;
        o.hit = chg > eps_reg;
      end
      CMD_READ: o.value = grid_copy[newest][at];
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_item(cmd_e cmd, int row, int col, logic [22:0] val);
    outcome_t o;
    int gap;
    s_axis_tdata = {3'b0, val, col[5:0], row[5:0], cmd};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    o = predict_grid(cmd, row, col, val);
    expected_q.push_back(o);
    items_sent++;
    if (cmd == CMD_RUN) begin
      runs_sent++;
      if (o.hit) limit_hits++;
    end
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // lets every pending result drain, then gives the block time to go idle
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_reg(reg_e idx, int unsigned data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data[22:0];
    case (idx)
      REG_GRID_SIZE:  size_reg = data & 32'h7f;
      REG_EPSILON:    eps_reg = data & 32'h7fffff;
      REG_MAX_SWEEPS: sweeps_reg = data & 32'hffff;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // every cell of the active grid has to hold a value before a run
  task automatic fill_grid(logic [22:0] mask);
    int unsigned n;
    n = size_reg < 3 ? 3 : (size_reg > Dim ? Dim : size_reg);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (!written[r * Dim + c]) send_item(CMD_WRITE, r, c, 23'($urandom()) & mask);
  endtask

  task automatic test_directed();
    set_reg(REG_GRID_SIZE, 0);
    set_reg(REG_EPSILON, 0);
    set_reg(REG_MAX_SWEEPS, 0);
    send_item(CMD_WRITE, 63, 63, 23'h7fffff);
    send_item(CMD_WRITE, 0, 63, 23'h000000);
    send_item(CMD_WRITE, 63, 0, 23'h555555);
    send_item(CMD_READ, 63, 63, '0);
    send_item(CMD_READ, 0, 63, 23'h7fffff);
    send_item(CMD_READ, 63, 0, '0);
    send_item(CMD_NONE, 63, 63, 23'h7fffff);
    // bright border around a dark center, clamped 3x3 grid
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_item(CMD_WRITE, r, c, (r == 1 && c == 1) ? 23'h0 : 23'h7fffff);
    send_item(CMD_RUN, 0, 0, '0);
    send_item(CMD_READ, 1, 1, '0);
    drain();
    set_reg(REG_EPSILON, 23'h7fffff);
    set_reg(REG_MAX_SWEEPS, 65535);
    send_item(CMD_RUN, 0, 0, '0);
    send_item(CMD_WRITE, 1, 1, 23'h2aaaaa);
    drain();
    set_reg(REG_EPSILON, 0);
    send_item(CMD_RUN, 63, 63, 23'h7fffff);
    send_item(CMD_READ, 1, 1, '0);
    drain();
  endtask

  task automatic pick_settings();
    int p;
    int unsigned sz, eps, lim;
    p = $urandom_range(99);
    if (p < 70) sz = $urandom_range(10, 3);
    else if (p < 82) sz = $urandom_range(20, 11);
    else sz = $urandom_range(2, 0);
    p = $urandom_range(99);
    if (p < 25) eps = 0;
    else if (p < 65) eps = $urandom_range(23'hffff);
    else if (p < 90) eps = $urandom() & 23'h7fffff;
    else eps = 23'h7fffff;
    p = $urandom_range(99);
    if (p < 80) lim = $urandom_range(24, 1);
    else if (p < 92) lim = 0;
    else lim = 65535;
    if (sz > 20) lim = $urandom_range(2, 1);
    else if (lim == 65535 && (sz > 6 || eps < 65536)) lim = 200;
    set_reg(REG_GRID_SIZE, sz);
    set_reg(REG_EPSILON, eps);
    set_reg(REG_MAX_SWEEPS, lim);
  endtask

  task automatic test_random();
    int p, r, c;
    int unsigned n;
    for (int ph = 0; ph < Phases; ph++) begin
      quiet = (ph == 2);
      drain();
      pick_settings();
      fill_grid($urandom_range(1) ? 23'h7fffff : 23'h03ffff);
      n = size_reg < 3 ? 3 : (size_reg > Dim ? Dim : size_reg);
      for (int i = 0; i < RandomItems / Phases; i++) begin
        if (ph == 4 && i == RandomItems / Phases / 2) drain();
        p = $urandom_range(99);
        if (p < 40) begin
          if ($urandom_range(99) < 70) begin
            r = $urandom_range(n - 1);
            c = $urandom_range(n - 1);
          end else begin
            r = $urandom_range(Dim - 1);
            c = $urandom_range(Dim - 1);
          end
          send_item(CMD_WRITE, r, c, 23'($urandom()));
        end else if (p < 75) begin
          r = $urandom_range(Dim - 1);
          c = $urandom_range(Dim - 1);
          if (!written[r * Dim + c]) begin
            r = $urandom_range(n - 1);
            c = $urandom_range(n - 1);
          end
          send_item(CMD_READ, r, c, 23'($urandom()));
        end else if (p < 88) begin
          send_item(CMD_RUN, $urandom_range(63), $urandom_range(63), 23'($urandom()));
        end else begin
          send_item(CMD_NONE, $urandom_range(63), $urandom_range(63),
                    23'($urandom()));
        end
      end
    end
    quiet = 1'b0;
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      m_axis_tready = rst_ni;
    end else if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if ($urandom_range(99) < 25) begin
      m_axis_tready = 1'b0;
      stall_left = $urandom_range(99) < 85 ? $urandom_range(2) : $urandom_range(40, 5);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    outcome_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[62:0];
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer %h", m_axis_tdata);
      end else begin
        want = expected_q.pop_front();
        if (got.value !== want.value || got.sweeps !== want.sweeps ||
            got.change !== want.change || got.hit !== want.hit) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: value %h/%h sweeps %0d/%0d change %h/%h limit %b/%b",
                     results_seen, want.value, got.value, want.sweeps, got.sweeps,
                     want.change, got.change, want.hit, got.hit);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("jacobi_grid_relaxation verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Cells; i++) begin
      grid_copy[0][i] = '0;
      grid_copy[1][i] = '0;
      written[i] = 1'b0;
    end
    newest = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    drain();
    $display("%0d items sent, %0d results checked, %0d relaxation runs (%0d hit the limit)",
             items_sent, results_seen, runs_sent, limit_hits);
    $display("%0d mismatches, %0d cycles", errors, cycles);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("jacobi_grid_relaxation verification clean");
    end else begin
      $display("jacobi_grid_relaxation verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/jgr_pkg.sv
sv/jgr_datapath.sv
sv/jgr_ctrl.sv
sv/jacobi_grid_relaxation.sv
test/tb.sv
